### hdl/lhist_pkg.sv
// ----------------------------------------------------------------------------
// lhist_pkg: shared definitions for the log2 latency histogram
// Table and histogram sizes, field widths, request and status codes, and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhist_pkg;

	// table and histogram sizes
	localparam int TABLE_DEPTH = 1024;
	localparam int HIST_SLOTS  = 32;

	localparam int TAB_AW  = $clog2(TABLE_DEPTH);
	localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
	localparam int HIST_IW = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;

	// field widths
	localparam int REQ_W   = 2;
	localparam int TASK_W  = 22;
	localparam int TIME_W  = 64;
	localparam int SLOT_W  = 6;
	localparam int LAT_W   = 55;
	localparam int CNT_W   = 64;
	localparam int ENTRY_W = TASK_W + TIME_W;

	// nanoseconds to microseconds: 1000 = 8 * 125, shift then reciprocal multiply
	localparam int US_DIV    = 1000;
	localparam int DIV_SH    = 3;
	localparam int DIV_ODD   = US_DIV >> DIV_SH;
	localparam int DVD_W     = TIME_W - DIV_SH;
	localparam int RCP_SH    = DVD_W + 7;
	localparam int RCP_W     = 62;
	localparam int MUL_W     = 32;
	localparam int ACC_W     = DVD_W + RCP_W;
	localparam int DIV_STEPS = 5;
	localparam int STEP_W    = 3;

	// ceil(2^RCP_SH / 125), exact for every dividend below 2^DVD_W
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((128'd1 << RCP_SH) + 128'(DIV_ODD - 1)) / 128'(DIV_ODD));

	// request codes
	typedef logic [REQ_W-1:0] req_t;
	localparam req_t REQ_START  = 2'd0;
	localparam req_t REQ_FINISH = 2'd1;
	localparam req_t REQ_READ   = 2'd2;

	// result status codes
	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_COUNTED = 3'd2,
		ST_IGNORED = 3'd3,
		ST_READ    = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan;
		logic    store;
		logic    move_rd;
		logic    move_wr;
		logic    div_step;
		logic    hist_inc;
		logic    rsp_load;
		status_t rsp_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic hit;
		logic full;
		logic div_last;
		logic rsp_free;
	} sts_t;

endpackage

`default_nettype wire

### hdl/lhist_ram.sv
// ----------------------------------------------------------------------------
// lhist_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/lhist_dp.sv
// ----------------------------------------------------------------------------
// lhist_dp: datapath of the log2 latency histogram
// Packed task table in RAM with a fill count, one-entry-per-cycle id search,
// divide by 1000 through a multi-cycle reciprocal multiply, bit-length slot
// selection, slot counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhist_dp
	import lhist_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [TASK_W-1:0] task_id,
	input  wire logic [TIME_W-1:0] time_ns,
	input  wire logic [SLOT_W-1:0] read_slot,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [LAT_W-1:0]       latency_us,
	output logic [CNT_W-1:0]       count
);

	// captured item
	logic [TASK_W-1:0] task_q;
	logic [TIME_W-1:0] time_q;
	logic [SLOT_W-1:0] rslot_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			task_q  <= task_id;
			time_q  <= time_ns;
			rslot_q <= read_slot;
		end
	end

	// table search state
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  scan_q;
	logic               chk_q;
	logic [TAB_AW-1:0]  chk_idx_q;
	logic               hit_q;
	logic [TAB_AW-1:0]  hit_idx_q;
	logic [TIME_W-1:0]  hit_time_q;
	logic [ENTRY_W-1:0] rd_data;
	logic [TASK_W-1:0]  rd_task;
	logic [TIME_W-1:0]  rd_time;
	logic [FILL_W-1:0]  last_idx;
	logic               scan_issue;
	logic               match;

	assign rd_task    = rd_data[ENTRY_W-1:TIME_W];
	assign rd_time    = rd_data[TIME_W-1:0];
	assign last_idx   = fill_q - FILL_W'(1);
	assign scan_issue = cmd.scan && !hit_q && (scan_q < fill_q);
	assign match      = chk_q && !hit_q && (rd_task == task_q);

	// table memory: live entries are packed at the low end
	logic              ram_we;
	logic [TAB_AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic              ram_re;
	logic [TAB_AW-1:0] ram_raddr;

	always_comb begin
		ram_we    = cmd.store || cmd.move_wr;
		ram_waddr = (cmd.move_wr || hit_q) ? hit_idx_q : fill_q[TAB_AW-1:0];
		ram_wdata = cmd.move_wr ? rd_data : {task_q, time_q};
		ram_re    = scan_issue || cmd.move_rd;
		ram_raddr = cmd.move_rd ? last_idx[TAB_AW-1:0] : scan_q[TAB_AW-1:0];
	end

	lhist_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// search control and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			scan_q <= '0;
			chk_q  <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				chk_q  <= 1'b0;
				hit_q  <= 1'b0;
			end else begin
				chk_q <= scan_issue;
				if (scan_issue) begin
					scan_q <= scan_q + FILL_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.store && !hit_q) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (cmd.move_wr) begin
				fill_q <= last_idx;
			end
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			chk_idx_q <= scan_q[TAB_AW-1:0];
		end
		if (match) begin
			hit_idx_q  <= chk_idx_q;
			hit_time_q <= rd_time;
		end
	end

	// divide by 1000: drop the factor 8 by a shift, then multiply by the
	// reciprocal of 125, one 32x32 partial product per cycle
	logic [DVD_W-1:0]  dvd_q;
	logic [STEP_W-1:0] step_q;
	logic [63:0]       prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [TIME_W-1:0] elapsed;
	logic [MUL_W-1:0]  dvd_lo;
	logic [MUL_W-1:0]  dvd_hi;
	logic [MUL_W-1:0]  rcp_lo;
	logic [MUL_W-1:0]  rcp_hi;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [ACC_W-1:0]  prod_ext;
	logic [ACC_W-1:0]  prod_sh;
	logic [LAT_W-1:0]  quo;

	assign elapsed = time_q - hit_time_q;
	assign dvd_lo  = dvd_q[MUL_W-1:0];
	assign dvd_hi  = MUL_W'(dvd_q[DVD_W-1:MUL_W]);
	assign rcp_lo  = RCP[MUL_W-1:0];
	assign rcp_hi  = MUL_W'(RCP[RCP_W-1:MUL_W]);

	// steps 0..3 form lo*lo, lo*hi, hi*lo, hi*hi; each is added one step later
	always_comb begin
		mul_a    = step_q[1] ? dvd_hi : dvd_lo;
		mul_b    = step_q[0] ? rcp_hi : rcp_lo;
		prod_ext = ACC_W'(prod_q);
		unique case (step_q)
			STEP_W'(0):             prod_sh = '0;
			STEP_W'(1):             prod_sh = prod_ext;
			STEP_W'(DIV_STEPS - 1): prod_sh = prod_ext << (2 * MUL_W);
			default:                prod_sh = prod_ext << MUL_W;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.move_rd) begin
			dvd_q  <= elapsed[TIME_W-1:DIV_SH];
			step_q <= '0;
			acc_q  <= '0;
		end else if (cmd.div_step) begin
			prod_q <= mul_a * mul_b;
			acc_q  <= acc_q + prod_sh;
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign quo = acc_q[RCP_SH +: LAT_W];

	// bit length of the quotient
	function automatic logic [SLOT_W-1:0] bit_len(logic [LAT_W-1:0] v);
		logic [SLOT_W-1:0] n;
		n = '0;
		for (int i = 0; i < LAT_W; i++) begin
			if (v[i]) begin
				n = SLOT_W'(i + 1);
			end
		end
		return n;
	endfunction

	// slot selection
	logic [SLOT_W-1:0]  blen;
	logic [SLOT_W-1:0]  hslot;
	logic [HIST_IW-1:0] inc_idx;
	logic [HIST_IW-1:0] rd_idx;
	logic               rd_ok;

	assign blen    = bit_len(quo);
	assign hslot   = (blen >= SLOT_W'(HIST_SLOTS - 1)) ? SLOT_W'(HIST_SLOTS - 1) : blen;
	assign inc_idx = hslot[HIST_IW-1:0];
	assign rd_idx  = rslot_q[HIST_IW-1:0];
	assign rd_ok   = {1'b0, rslot_q} < (SLOT_W + 1)'(HIST_SLOTS);

	// histogram counters
	logic [CNT_W-1:0] hist_q [HIST_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_SLOTS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.hist_inc) begin
			hist_q[inc_idx] <= hist_q[inc_idx] + CNT_W'(1);
		end
	end

	// result fields
	logic [SLOT_W-1:0] nxt_slot;
	logic [LAT_W-1:0]  nxt_lat;
	logic [CNT_W-1:0]  nxt_cnt;

	always_comb begin
		nxt_slot = '0;
		nxt_lat  = '0;
		nxt_cnt  = '0;
		unique case (cmd.rsp_status)
			ST_COUNTED: begin
				nxt_slot = hslot;
				nxt_lat  = quo;
				nxt_cnt  = hist_q[inc_idx];
			end
			ST_READ: begin
				nxt_slot = rslot_q;
				nxt_cnt  = rd_ok ? hist_q[rd_idx] : '0;
			end
			default: begin
				nxt_slot = '0;
			end
		endcase
	end

	// result register
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			status     <= cmd.rsp_status;
			slot       <= nxt_slot;
			latency_us <= nxt_lat;
			count      <= nxt_cnt;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// status to controller
	always_comb begin
		sts.scan_end = hit_q || (!chk_q && (scan_q >= fill_q));
		sts.hit      = hit_q;
		sts.full     = fill_q == FILL_W'(TABLE_DEPTH);
		sts.div_last = step_q == STEP_W'(DIV_STEPS - 1);
		sts.rsp_free = !rsp_valid_q || rsp_ready;
	end

endmodule

`default_nettype wire

### hdl/lhist_ctrl.sv
// ----------------------------------------------------------------------------
// lhist_ctrl: controller of the log2 latency histogram
// Sequences search, store, entry removal, division, counting and the result
// hand-off for one item at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhist_ctrl
	import lhist_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req_type,
	input  wire sts_t       sts,
	output cmd_t            cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_STORE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DIV,
		S_COUNT,
		S_RESP
	} state_t;

	state_t  state_q;
	req_t    type_q;
	status_t rsp_status_q;

	// state and registered result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			type_q       <= REQ_START;
			rsp_status_q <= ST_IGNORED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q <= req_type;
						if (req_type == REQ_START || req_type == REQ_FINISH) begin
							state_q <= S_SCAN;
						end else if (req_type == REQ_READ) begin
							rsp_status_q <= ST_READ;
							state_q      <= S_RESP;
						end else begin
							rsp_status_q <= ST_IGNORED;
							state_q      <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (sts.scan_end) begin
						if (type_q == REQ_START) begin
							if (sts.hit || !sts.full) begin
								rsp_status_q <= ST_STORED;
								state_q      <= S_STORE;
							end else begin
								rsp_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end
						end else if (sts.hit) begin
							rsp_status_q <= ST_COUNTED;
							state_q      <= S_MOVE_RD;
						end else begin
							rsp_status_q <= ST_IGNORED;
							state_q      <= S_RESP;
						end
					end
				end
				S_STORE: begin
					state_q <= S_RESP;
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.load       = (state_q == S_IDLE) && req_valid;
		cmd.scan       = state_q == S_SCAN;
		cmd.store      = state_q == S_STORE;
		cmd.move_rd    = state_q == S_MOVE_RD;
		cmd.move_wr    = state_q == S_MOVE_WR;
		cmd.div_step   = state_q == S_DIV;
		cmd.hist_inc   = state_q == S_COUNT;
		cmd.rsp_load   = (state_q == S_RESP) && sts.rsp_free;
		cmd.rsp_status = rsp_status_q;
	end

	assign req_ready = state_q == S_IDLE;

endmodule

`default_nettype wire

### hdl/latency_log2_histogram_unit.sv
// ----------------------------------------------------------------------------
// latency_log2_histogram_unit: per-task latency log2 histogram
// Start events store a timestamp per task id, finish events turn the elapsed
// time into microseconds and count its bit length, read requests return one
// slot counter.
// ----------------------------------------------------------------------------
// The id search reads one table entry per cycle; the divide by 1000
// accumulates 32x32 partial products, one per step.
// One item at a time: the next item can be accepted in the cycle after a
// result is loaded, even while it waits. Reset clears the fill count and all slots.
`timescale 1ns / 1ps
`default_nettype none

module latency_log2_histogram_unit
	import lhist_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [TASK_W-1:0] task_id,
	input  wire logic [TIME_W-1:0] time_ns,
	input  wire logic [SLOT_W-1:0] read_slot,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [LAT_W-1:0]       latency_us,
	output logic [CNT_W-1:0]       count
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	lhist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, divider, counters and result register
	lhist_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.task_id   (task_id),
		.time_ns   (time_ns),
		.read_slot (read_slot),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.slot      (slot),
		.latency_us(latency_us),
		.count     (count)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for latency_log2_histogram_unit
// Start, finish, read and unknown requests go through the request handshake.
// Each accepted item updates a local copy of the task table and the slot
// counters, and the response it must produce is queued. A checker compares
// each response field with the oldest queued one. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import lhist_pkg::*;

	// request code the block does not define
	localparam req_t REQ_UNUSED = 2'd3;

	// cycles allowed after the last response for a stray extra one
	localparam int TAIL_CYCLES = 1200;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [LAT_W-1:0]  lat;
		logic [CNT_W-1:0]  cnt;
	} hist_rsp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [REQ_W-1:0]  req_type = '0;
	logic [TASK_W-1:0] task_id = '0;
	logic [TIME_W-1:0] time_ns = '0;
	logic [SLOT_W-1:0] read_slot = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [2:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [LAT_W-1:0]  latency_us;
	logic [CNT_W-1:0]  count;

	// local copy of the task table and the histogram
	bit              tbl_valid [TABLE_DEPTH];
	bit [TASK_W-1:0] tbl_task  [TABLE_DEPTH];
	bit [TIME_W-1:0] tbl_start [TABLE_DEPTH];
	bit [CNT_W-1:0]  slot_cnt  [HIST_SLOTS];

	// responses still owed by the block, oldest first
	hist_rsp_t awaited_rsp [$];
	hist_rsp_t head_rsp;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int n_errors = 0;

	latency_log2_histogram_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.task_id    (task_id),
		.time_ns    (time_ns),
		.read_slot  (read_slot),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.slot       (slot),
		.latency_us (latency_us),
		.count      (count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int find_entry(logic [TASK_W-1:0] id);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_valid[i] && tbl_task[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic int first_free();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!tbl_valid[i])
				return i;
		end
		return -1;
	endfunction

	// update the table and counters for one item, return its response
	function automatic hist_rsp_t predict_rsp(req_t req, logic [TASK_W-1:0] id,
			logic [TIME_W-1:0] now, logic [SLOT_W-1:0] rslot);
		hist_rsp_t         r;
		int                e;
		int                nbits;
		logic [TIME_W-1:0] us;
		logic [TIME_W-1:0] v;
		r.status = ST_IGNORED;
		r.slot   = '0;
		r.lat    = '0;
		r.cnt    = '0;
		case (req)
			REQ_START: begin
				// same id reuses its entry, else lowest free one
				e = find_entry(id);
				if (e < 0)
					e = first_free();
				if (e < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_valid[e] = 1'b1;
					tbl_task[e]  = id;
					tbl_start[e] = now;
					r.status = ST_STORED;
				end
			end
			REQ_FINISH: begin
				e = find_entry(id);
				if (e >= 0) begin
					// elapsed time wraps mod 2^64 before the divide
					us = (now - tbl_start[e]) / TIME_W'(US_DIV);
					nbits = 0;
					v = us;
					while (v != 0) begin
						nbits++;
						v = v >> 1;
					end
					if (nbits > HIST_SLOTS - 1)
						nbits = HIST_SLOTS - 1;
					tbl_valid[e] = 1'b0;
					slot_cnt[nbits] = slot_cnt[nbits] + 1'b1;
					r.status = ST_COUNTED;
					r.slot   = SLOT_W'(nbits);
					r.lat    = LAT_W'(us);
					r.cnt    = slot_cnt[nbits];
				end
			end
			REQ_READ: begin
				r.status = ST_READ;
				r.slot   = rslot;
				if (rslot < HIST_SLOTS)
					r.cnt = slot_cnt[rslot];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// offer one item, with random idle cycles first
	task automatic send_item(req_t req, logic [TASK_W-1:0] id, logic [TIME_W-1:0] t,
			logic [SLOT_W-1:0] rslot);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= req;
		task_id   <= id;
		time_ns   <= t;
		read_slot <= rslot;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		awaited_rsp.push_back(predict_rsp(req, id, t, rslot));
	endtask

	// hold off the sender until every owed response has come
	task automatic wait_results_drained();
		if (awaited_rsp.size() != 0) begin
			req_valid <= 1'b0;
			while (awaited_rsp.size() != 0)
				@(posedge clk);
		end
	endtask

	// response checker and random receiver stalls
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$error("response with none owed: status %0d slot %0d", status, slot);
				n_errors++;
			end else begin
				head_rsp = awaited_rsp.pop_front();
				if (status !== head_rsp.status) begin
					$error("status: expected %0d, got %0d", head_rsp.status, status);
					n_errors++;
				end
				if (slot !== head_rsp.slot) begin
					$error("slot: expected %0d, got %0d", head_rsp.slot, slot);
					n_errors++;
				end
				if (latency_us !== head_rsp.lat) begin
					$error("latency_us: expected %0d, got %0d", head_rsp.lat, latency_us);
					n_errors++;
				end
				if (count !== head_rsp.cnt) begin
					$error("count: expected %0d, got %0d", head_rsp.cnt, count);
					n_errors++;
				end
			end
		end
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// reads of empty, last, and out of range slots
	task automatic test_read_paths();
		send_item(REQ_READ, '0, '0, 6'd0);
		send_item(REQ_READ, '0, '0, 6'd31);
		send_item(REQ_READ, '0, '0, 6'd32);
		send_item(REQ_READ, '1, '1, 6'd63);
	endtask

	// undefined request type is ignored
	task automatic test_unknown_request();
		send_item(REQ_UNUSED, '1, '1, '1);
	endtask

	// matches, overwrite, misses, slot cap and time wrap
	task automatic test_latency_counting();
		send_item(REQ_FINISH, 22'h15, 64'd100, 6'd0);
		send_item(REQ_START, '0, '0, 6'd0);
		send_item(REQ_FINISH, '0, 64'd999, 6'd0);
		send_item(REQ_START, '1, 64'd1000, 6'd0);
		send_item(REQ_FINISH, '1, 64'd2999, 6'd0);
		// overwrite keeps the later start time
		send_item(REQ_START, 22'd7, 64'd5000, 6'd0);
		send_item(REQ_START, 22'd7, 64'd10000, 6'd0);
		send_item(REQ_FINISH, 22'd7, 64'd10000 + 64'd2147483648000, 6'd0);
		// entry is gone after its finish
		send_item(REQ_FINISH, 22'd7, 64'd20000, 6'd0);
		// timestamp going backwards wraps
		send_item(REQ_START, 22'd9, '1, 6'd0);
		send_item(REQ_FINISH, 22'd9, '0, 6'd0);
		send_item(REQ_START, 22'd9, 64'd100, 6'd0);
		send_item(REQ_FINISH, 22'd9, 64'd50, 6'd0);
		// largest possible latency
		send_item(REQ_START, 22'd3, '0, 6'd0);
		send_item(REQ_FINISH, 22'd3, '1, 6'd0);
		send_item(REQ_READ, '0, '0, 6'd0);
		send_item(REQ_READ, '0, '0, 6'd1);
		send_item(REQ_READ, '0, '0, 6'd31);
	endtask

	// start/finish pairs on a small id pool, with reads and noise
	task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
		logic [TASK_W-1:0] pool [12];
		logic [TASK_W-1:0] id;
		logic [TIME_W-1:0] clock_ns;
		req_t              req;
		int                pick;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		foreach (pool[i])
			pool[i] = TASK_W'($urandom);
		clock_ns = {$urandom, $urandom};
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(99);
			id = pool[$urandom_range(11)];
			if (pick < 42)
				req = REQ_START;
			else if (pick < 80)
				req = REQ_FINISH;
			else if (pick < 90)
				req = REQ_READ;
			else if (pick < 94)
				req = REQ_UNUSED;
			else begin
				req = (pick < 97) ? REQ_START : REQ_FINISH;
				id = TASK_W'($urandom);
			end
			// steps of every magnitude, occasionally wrapping
			clock_ns = clock_ns + ({$urandom, $urandom} >> $urandom_range(63, 0));
			send_item(req, id, clock_ns, SLOT_W'($urandom));
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_read_paths();
		test_unknown_request();
		test_latency_counting();
		wait_results_drained();
		test_random_traffic(134, 10, 82);
		test_random_traffic(133, 82, 10);
		test_random_traffic(133, 0, 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("PASS latency_log2_histogram_unit");
		else
			$display("FAIL latency_log2_histogram_unit");
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("FAIL latency_log2_histogram_unit");
		$finish;
	end

endmodule

### latency_log2_histogram_unit.f
hdl/lhist_pkg.sv
hdl/lhist_ram.sv
hdl/lhist_dp.sv
hdl/lhist_ctrl.sv
hdl/latency_log2_histogram_unit.sv
tb/tb_top.sv
